[rtl/rbp_pkg.sv]
// types and constants shared by the recolor brush pixel pipeline
package rbp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_REPLACE  = 3'd1;
  localparam logic [2:0] REG_TOL      = 3'd2;
  localparam logic [2:0] REG_OPACITY  = 3'd3;
  localparam logic [2:0] REG_HARDNESS = 3'd4;

  // stage map
  localparam int NUM_STAGES = 38;
  localparam int SQ_FIRST   = 3;   // sqrt and ramp divide, one digit a stage
  localparam int SQ_LAST    = 18;
  localparam int MIX_STAGE  = 19;
  localparam int DIV_STAGE  = 20;
  localparam int FO_FIRST   = 21;  // falloff divide, one digit a stage
  localparam int FO_LAST    = 36;
  localparam int FALL_STAGE = 37;

  // ceil(2^30/100), exact floor(x/100) for x below 2^23
  localparam logic [23:0] RECIP_100 = 24'd10737419;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  typedef struct packed {
    logic [7:0]  r;
    logic        allowed;
    logic [7:0]  pr;
    logic [7:0]  pg;
    logic [7:0]  pb;
    logic [7:0]  pa;
    logic [17:0] d2;
    logic [15:0] r2;
    logic [9:0]  diff;
    logic [9:0]  lim;
    logic [6:0]  op;
    logic [6:0]  hd;
    logic        pass;
    logic        special;
    logic [30:0] lhs;
    logic [13:0] hh;
    logic [29:0] rhs;
    logic        gt;
    logic [31:0] sv;
    logic [17:0] srem;
    logic [15:0] sroot;
    logic [9:0]  drem;
    logic [15:0] dq;
    logic [16:0] f;
    logic [22:0] fm;
    logic [22:0] a;
    logic [22:0] dd;
    logic        clampf;
    logic [22:0] frem;
    logic [15:0] fq;
  } stage_t;

endpackage

[rtl/recolor_brush_pixel_top.sv]
// recolor brush pixel: tolerance colour replace under a round soft dab
// throughput: one pixel per cycle when not stalled, set by the 38-stage datapath; the
//   square root and both divides take one digit per stage over 16 stages each
// whole pipeline advances together; it stalls only while the output holds a result and m_tready is low
// reset (rst, synchronous) clears all stage valids and loads register defaults
module recolor_brush_pixel_top #(
  parameter int MAX_RADIUS = 255
) (
  input  logic        clk,
  input  logic        rst,
  // offset_x[8:0] offset_y[17:9] radius[25:18] pixel_red[33:26]
  // pixel_green[41:34] pixel_blue[49:42] pixel_alpha[57:50], rest zero
  input  logic [63:0] s_tdata,
  input  logic [0:0]  s_tuser,   // allowed[0]
  input  logic        s_tvalid,
  output logic        s_tready,
  // out_red[7:0] out_green[15:8] out_blue[23:16] out_alpha[31:24]
  output logic [31:0] m_tdata,
  output logic [0:0]  m_tuser,   // written[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import rbp_pkg::*;

  localparam logic [9:0] MAXR = MAX_RADIUS[9:0];

  // configuration registers
  logic [23:0] target_color;
  logic [23:0] replace_color;
  logic [7:0]  tolerance;
  logic [6:0]  opacity_percent;
  logic [6:0]  hardness_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_color     <= '0;
      replace_color    <= '0;
      tolerance        <= '0;
      opacity_percent  <= 7'd100;
      hardness_percent <= 7'd100;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TARGET:   target_color     <= cfg_data;
        REG_REPLACE:  replace_color    <= cfg_data;
        REG_TOL:      tolerance        <= cfg_data[7:0];
        REG_OPACITY:  opacity_percent  <= cfg_data[6:0];
        REG_HARDNESS: hardness_percent <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // pipeline registers, valid bit per stage
  stage_t                  p  [1:NUM_STAGES];
  stage_t                  nx [1:NUM_STAGES];
  logic   [NUM_STAGES:1]   vld;
  logic                    en;

  // whole pipe moves unless the output stage holds an untaken result
  assign en       = !vld[NUM_STAGES] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-1:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        p[k] <= nx[k];
      end
    end
  end

  genvar k;
  generate
    for (k = 1; k <= NUM_STAGES; k++) begin : g_stage
      if (k == 1) begin : g_front
        // squares, colour distance, saturation of radius and percents
        always_comb begin
          logic signed [8:0]  dx;
          logic signed [8:0]  dy;
          logic signed [17:0] sx;
          logic signed [17:0] sy;
          logic [7:0]         rin;
          logic [7:0]         tr;
          logic [7:0]         tg;
          logic [7:0]         tb;
          logic [7:0]         ar;
          logic [7:0]         ag;
          logic [7:0]         ab;
          dx  = s_tdata[8:0];
          dy  = s_tdata[17:9];
          sx  = dx * dx;
          sy  = dy * dy;
          rin = s_tdata[25:18];
          tr  = target_color[23:16];
          tg  = target_color[15:8];
          tb  = target_color[7:0];
          nx[k]         = '0;
          nx[k].r       = ({2'b00, rin} > MAXR) ? MAXR[7:0] : rin;
          nx[k].allowed = s_tuser[0];
          nx[k].pr      = s_tdata[33:26];
          nx[k].pg      = s_tdata[41:34];
          nx[k].pb      = s_tdata[49:42];
          nx[k].pa      = s_tdata[57:50];
          nx[k].d2      = 18'(sx) + 18'(sy);
          nx[k].r2      = 16'(nx[k].r * nx[k].r);
          ar = (nx[k].pr > tr) ? nx[k].pr - tr : tr - nx[k].pr;
          ag = (nx[k].pg > tg) ? nx[k].pg - tg : tg - nx[k].pg;
          ab = (nx[k].pb > tb) ? nx[k].pb - tb : tb - nx[k].pb;
          nx[k].diff = {2'b00, ar} + {2'b00, ag} + {2'b00, ab};
          nx[k].lim  = 10'(3 * tolerance);
          nx[k].op   = (opacity_percent > 7'd100) ? 7'd100 : opacity_percent;
          nx[k].hd   = (hardness_percent > 7'd100) ? 7'd100 : hardness_percent;
        end
      end else if (k == 2) begin : g_test
        // accept tests, start of sqrt and ramp divide
        always_comb begin
          nx[k]         = p[k-1];
          nx[k].pass    = (p[k-1].d2 <= {2'b00, p[k-1].r2}) && p[k-1].allowed &&
                          (p[k-1].diff <= p[k-1].lim);
          nx[k].special = (p[k-1].lim == '0) || (p[k-1].diff == '0);
          nx[k].drem    = nx[k].special ? '0 : p[k-1].lim - p[k-1].diff;
          nx[k].dq      = '0;
          nx[k].sv      = {p[k-1].d2[15:0], 16'h0000};
          nx[k].srem    = '0;
          nx[k].sroot   = '0;
          nx[k].lhs     = 31'(p[k-1].d2 * 14'd10000);
          nx[k].hh      = 14'(p[k-1].hd * p[k-1].hd);
        end
      end else if (k >= SQ_FIRST && k <= SQ_LAST) begin : g_sq
        // one root digit and one quotient bit of the ramp
        always_comb begin
          logic [19:0] rr;
          logic [19:0] trial;
          logic [10:0] dt;
          nx[k] = p[k-1];
          rr    = {p[k-1].srem, p[k-1].sv[31:30]};
          trial = {2'b00, p[k-1].sroot, 2'b01};
          nx[k].sv = {p[k-1].sv[29:0], 2'b00};
          if (rr >= trial) begin
            nx[k].srem  = 18'(rr - trial);
            nx[k].sroot = {p[k-1].sroot[14:0], 1'b1};
          end else begin
            nx[k].srem  = rr[17:0];
            nx[k].sroot = {p[k-1].sroot[14:0], 1'b0};
          end
          dt = {p[k-1].drem, 1'b0};
          if (dt >= {1'b0, p[k-1].lim}) begin
            nx[k].drem = 10'(dt - {1'b0, p[k-1].lim});
            nx[k].dq   = {p[k-1].dq[14:0], 1'b1};
          end else begin
            nx[k].drem = dt[9:0];
            nx[k].dq   = {p[k-1].dq[14:0], 1'b0};
          end
          if (k == SQ_FIRST) begin
            nx[k].rhs = 30'(p[k-1].hh * p[k-1].r2);
          end
          if (k == SQ_FIRST + 1) begin
            nx[k].gt = {1'b0, p[k-1].lhs} > {2'b00, p[k-1].rhs};
          end
        end
      end else if (k == MIX_STAGE) begin : g_mix
        // ramp times opacity, falloff numerator and denominator
        always_comb begin
          logic [16:0] f0;
          logic [15:0] rs;
          logic [15:0] t;
          f0       = p[k-1].special ? ONE_Q16 : {1'b0, p[k-1].dq};
          rs       = {p[k-1].r, 8'h00};
          t        = rs - p[k-1].sroot;
          nx[k]    = p[k-1];
          nx[k].f  = f0;
          nx[k].fm = 23'(f0 * p[k-1].op);
          nx[k].a  = 23'(t * 7'd100);
          nx[k].dd = 23'(rs * (7'd100 - p[k-1].hd));
        end
      end else if (k == DIV_STAGE) begin : g_div
        // divide by 100 through the reciprocal, falloff divide start
        always_comb begin
          logic [46:0] pm;
          pm           = p[k-1].fm * RECIP_100;
          nx[k]        = p[k-1];
          nx[k].f      = pm[46:30];
          nx[k].clampf = p[k-1].a >= p[k-1].dd;
          nx[k].frem   = nx[k].clampf ? '0 : p[k-1].a;
          nx[k].fq     = '0;
        end
      end else if (k >= FO_FIRST && k <= FO_LAST) begin : g_fo
        always_comb begin
          logic [23:0] ft;
          nx[k] = p[k-1];
          ft    = {p[k-1].frem, 1'b0};
          if (ft >= {1'b0, p[k-1].dd}) begin
            nx[k].frem = 23'(ft - {1'b0, p[k-1].dd});
            nx[k].fq   = {p[k-1].fq[14:0], 1'b1};
          end else begin
            nx[k].frem = ft[22:0];
            nx[k].fq   = {p[k-1].fq[14:0], 1'b0};
          end
        end
      end else if (k == FALL_STAGE) begin : g_fall
        // soft edge applies only outside the hard core
        always_comb begin
          logic        apply;
          logic [16:0] fo;
          logic [33:0] pf;
          apply = (p[k-1].r != '0) && (p[k-1].hd < 7'd100) && p[k-1].gt;
          if (p[k-1].d2 >= {2'b00, p[k-1].r2}) begin
            fo = '0;
          end else if (p[k-1].clampf) begin
            fo = ONE_Q16;
          end else begin
            fo = {1'b0, p[k-1].fq};
          end
          pf      = p[k-1].f * fo;
          nx[k]   = p[k-1];
          nx[k].f = apply ? pf[32:16] : p[k-1].f;
        end
      end else begin : g_blend
        // per channel blend, rejected pixels pass unchanged
        always_comb begin
          logic [16:0] fi;
          logic [25:0] br;
          logic [25:0] bg;
          logic [25:0] bb;
          fi = ONE_Q16 - p[k-1].f;
          br = 26'(replace_color[23:16] * p[k-1].f) + 26'(p[k-1].pr * fi);
          bg = 26'(replace_color[15:8] * p[k-1].f) + 26'(p[k-1].pg * fi);
          bb = 26'(replace_color[7:0] * p[k-1].f) + 26'(p[k-1].pb * fi);
          nx[k] = p[k-1];
          if (p[k-1].pass) begin
            nx[k].pr = (br[25:16] > 10'd255) ? 8'hFF : br[23:16];
            nx[k].pg = (bg[25:16] > 10'd255) ? 8'hFF : bg[23:16];
            nx[k].pb = (bb[25:16] > 10'd255) ? 8'hFF : bb[23:16];
          end
        end
      end
    end
  endgenerate

  assign m_tvalid = vld[NUM_STAGES];
  assign m_tdata  = {p[NUM_STAGES].pa, p[NUM_STAGES].pb, p[NUM_STAGES].pg, p[NUM_STAGES].pr};
  assign m_tuser  = p[NUM_STAGES].pass;

  // an accepted transaction always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[1])
    else $error("accepted transaction lost at pipe entry");

  // a stall freezes every valid bit
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during stall");

  // a written pixel was allowed
  a_allowed: assert property (@(posedge clk) disable iff (rst)
    (vld[NUM_STAGES] && p[NUM_STAGES].pass) |-> p[NUM_STAGES].allowed)
    else $error("disallowed pixel written");

  // falloff remainder stays below divisor
  a_frem: assert property (@(posedge clk) disable iff (rst)
    vld[FO_LAST] |-> (p[FO_LAST].clampf || (p[FO_LAST].frem < p[FO_LAST].dd)))
    else $error("falloff divide remainder out of range");

endmodule
